>>> hdl/fpa_pkg.sv
// shared types, constants and operation codes for the fixed-point alu
package fpa_pkg;
   localparam int FracBits = 8;
   localparam int WordBits = 32;
   // pipelined divider: one quotient bit per cell
   localparam int QuotBits = WordBits + FracBits + 1;
   localparam int DivBits  = WordBits + FracBits + 2;

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
      OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TO_INT, OP_FROM_INT
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   typedef struct packed {
      logic                  valid;
      logic                  is_div;
      logic                  neg;
      logic signed [WordBits-1:0] value;
      logic                  cmp;
      status_type            status;
   } tag_type;

   typedef struct packed {
      logic [DivBits-1:0] rem;
      logic [DivBits-1:0] num;
      logic [DivBits-1:0] den;
      logic [QuotBits-1:0] quot;
   } div_type;
endpackage

>>> hdl/fpa_front.sv
// first stage: decode, simple operations, multiply and divider operand set-up
module fpa_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          req_valid,
   input  logic [3:0]                    req_kind,
   input  logic signed [fpa_pkg::WordBits-1:0] req_operand_a,
   input  logic signed [fpa_pkg::WordBits-1:0] req_operand_b,
   output fpa_pkg::tag_type              tag_out,
   output logic                          mul_out,
   output logic [2*fpa_pkg::WordBits-1:0] prod_out,
   output fpa_pkg::div_type              div_out
);
   import fpa_pkg::*;

   localparam logic signed [WordBits+1:0] MaxV = (WordBits+2)'(2**(WordBits-1) - 1);
   localparam logic signed [WordBits+1:0] MinV = -MaxV - 1;

   tag_type tag_in, tag_ff;
   div_type div_in, div_ff;
   logic [2*WordBits-1:0] prod_in, prod_ff;
   logic [WordBits-1:0] mag_a, mag_b;
   logic signed [WordBits+1:0] wide;
   logic signed [WordBits+FracBits:0] shl;
   logic mul_in, mul_ff;
   op_type op;

   assign op = op_type'(req_kind);

   always_comb begin
      mag_a  = req_operand_a[WordBits-1] ? WordBits'(-req_operand_a) : req_operand_a;
      mag_b  = req_operand_b[WordBits-1] ? WordBits'(-req_operand_b) : req_operand_b;
      prod_in = {{WordBits{1'b0}}, mag_a} * {{WordBits{1'b0}}, mag_b};
      // divider works on 2n+d over 2d
      div_in.rem  = '0;
      div_in.num  = (DivBits)'({mag_a, {FracBits{1'b0}}, 1'b0}) + DivBits'(mag_b);
      div_in.den  = DivBits'({mag_b, 1'b0});
      div_in.quot = '0;
      shl = (WordBits+FracBits+1)'(req_operand_a) <<< FracBits;
      wide = '0;
      tag_in.valid  = req_valid;
      tag_in.is_div = 1'b0;
      tag_in.neg    = req_operand_a[WordBits-1] ^ req_operand_b[WordBits-1];
      tag_in.value  = '0;
      tag_in.cmp    = 1'b0;
      tag_in.status = ST_OK;
      unique case (op)
         OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
            unique case (op)
               OP_ADD:  wide = (WordBits+2)'(req_operand_a) + (WordBits+2)'(req_operand_b);
               OP_SUB:  wide = (WordBits+2)'(req_operand_a) - (WordBits+2)'(req_operand_b);
               OP_INC:  wide = (WordBits+2)'(req_operand_a) + (WordBits+2)'(1);
               default: wide = (WordBits+2)'(req_operand_a) - (WordBits+2)'(1);
            endcase
            if (wide > MaxV) begin
               tag_in.value = MaxV[WordBits-1:0]; tag_in.status = ST_OVF;
            end else if (wide < MinV) begin
               tag_in.value = MinV[WordBits-1:0]; tag_in.status = ST_OVF;
            end else tag_in.value = wide[WordBits-1:0];
         end
         OP_MUL: tag_in.is_div = 1'b0;
         OP_DIV: begin
            tag_in.is_div = 1'b1;
            if (req_operand_b == '0) begin
               tag_in.status = ST_DIV0;
               tag_in.value  = req_operand_a[WordBits-1] ? MinV[WordBits-1:0] :
                               (req_operand_a != '0) ? MaxV[WordBits-1:0] : '0;
            end
         end
         OP_GT: tag_in.cmp = req_operand_a >  req_operand_b;
         OP_LT: tag_in.cmp = req_operand_a <  req_operand_b;
         OP_GE: tag_in.cmp = req_operand_a >= req_operand_b;
         OP_LE: tag_in.cmp = req_operand_a <= req_operand_b;
         OP_EQ: tag_in.cmp = req_operand_a == req_operand_b;
         OP_NE: tag_in.cmp = req_operand_a != req_operand_b;
         OP_MIN: tag_in.value = (req_operand_a < req_operand_b) ? req_operand_a : req_operand_b;
         OP_MAX: tag_in.value = (req_operand_a > req_operand_b) ? req_operand_a : req_operand_b;
         OP_TO_INT: tag_in.value = req_operand_a >>> FracBits;
         default: begin
            if (shl > (WordBits+FracBits+1)'(MaxV)) begin
               tag_in.value = MaxV[WordBits-1:0]; tag_in.status = ST_OVF;
            end else if (shl < (WordBits+FracBits+1)'(MinV)) begin
               tag_in.value = MinV[WordBits-1:0]; tag_in.status = ST_OVF;
            end else tag_in.value = shl[WordBits-1:0];
         end
      endcase
   end

   // a multiply beat is finished in the next stage from the registered product
   assign mul_in = (op == OP_MUL);

   always_ff @(posedge clock) begin
      if (reset) tag_ff.valid <= 1'b0;
      else if (advance) tag_ff.valid <= tag_in.valid;
      if (advance) begin
         tag_ff.is_div <= tag_in.is_div;
         tag_ff.neg    <= tag_in.neg;
         tag_ff.value  <= tag_in.value;
         tag_ff.cmp    <= tag_in.cmp;
         tag_ff.status <= tag_in.status;
         mul_ff  <= mul_in;
         prod_ff <= prod_in;
         div_ff  <= div_in;
      end
   end

   assign tag_out  = tag_ff;
   assign mul_out  = mul_ff;
   assign prod_out = prod_ff;
   assign div_out  = div_ff;
endmodule

>>> hdl/fpa_mul_round.sv
// second stage: rounding, sign and saturation of the product
module fpa_mul_round (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           is_mul,
   input  fpa_pkg::tag_type               tag_in_port,
   input  logic [2*fpa_pkg::WordBits-1:0] prod,
   input  fpa_pkg::div_type               div_in_port,
   output fpa_pkg::tag_type               tag_out,
   output fpa_pkg::div_type               div_out
);
   import fpa_pkg::*;

   localparam logic [2*WordBits:0] MaxP = (2*WordBits+1)'(2**(WordBits-1) - 1);
   tag_type tag_in, tag_ff;
   div_type div_ff;
   logic [2*WordBits:0] r;

   always_comb begin
      tag_in = tag_in_port;
      r = ({1'b0, prod} + (2*WordBits+1)'(2**(FracBits-1))) >> FracBits;
      if (is_mul) begin
         if (!tag_in_port.neg) begin
            if (r > MaxP) begin
               tag_in.value = MaxP[WordBits-1:0]; tag_in.status = ST_OVF;
            end else tag_in.value = r[WordBits-1:0];
         end else begin
            if (r > MaxP + 1) begin
               tag_in.value = {1'b1, {(WordBits-1){1'b0}}}; tag_in.status = ST_OVF;
            end else tag_in.value = WordBits'(-r);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) tag_ff.valid <= 1'b0;
      else if (advance) tag_ff.valid <= tag_in.valid;
      if (advance) begin
         tag_ff.is_div <= tag_in.is_div;
         tag_ff.neg    <= tag_in.neg;
         tag_ff.value  <= tag_in.value;
         tag_ff.cmp    <= tag_in.cmp;
         tag_ff.status <= tag_in.status;
         div_ff <= div_in_port;
      end
   end

   assign tag_out = tag_ff;
   assign div_out = div_ff;
endmodule

>>> hdl/fpa_div_cell.sv
// one restoring-division cell: settles one quotient bit per beat
module fpa_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  fpa_pkg::tag_type tag_in_port,
   input  fpa_pkg::div_type div_in_port,
   output fpa_pkg::tag_type tag_out,
   output fpa_pkg::div_type div_out
);
   import fpa_pkg::*;

   tag_type tag_ff;
   div_type div_in, div_ff;
   logic [DivBits-1:0] trial;
   logic [DivBits:0] diff;

   always_comb begin
      div_in = div_in_port;
      trial  = {div_in_port.rem[DivBits-2:0], div_in_port.num[DivBits-1]};
      diff   = {1'b0, trial} - {1'b0, div_in_port.den};
      div_in.num = {div_in_port.num[DivBits-2:0], 1'b0};
      div_in.quot = {div_in_port.quot[QuotBits-2:0], ~diff[DivBits]};
      div_in.rem = diff[DivBits] ? trial : diff[DivBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) tag_ff.valid <= 1'b0;
      else if (advance) tag_ff.valid <= tag_in_port.valid;
      if (advance) begin
         tag_ff.is_div <= tag_in_port.is_div;
         tag_ff.neg    <= tag_in_port.neg;
         tag_ff.value  <= tag_in_port.value;
         tag_ff.cmp    <= tag_in_port.cmp;
         tag_ff.status <= tag_in_port.status;
         div_ff <= div_in;
      end
   end

   assign tag_out = tag_ff;
   assign div_out = div_ff;
endmodule

>>> hdl/fixed_point_alu_core.sv
// fixed-point alu top level: front stage, product rounding, divider cell row, output
// Signed fixed-point ALU on raw 32-bit values with 8 fraction bits. One beat is
// accepted per cycle unless the pipeline is held, and results leave in order;
// every beat passes through the same stages, among them the row of divider cells,
// one quotient bit per cell, whatever its operation. Multiply and divide round to
// nearest with ties away from zero; overflow saturates with status 1, divide by
// zero gives status 2. The whole pipeline holds while a result waits under rsp_stall.
module fixed_point_alu_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [3:0]                           req_kind,
   input  logic signed [fpa_pkg::WordBits-1:0]  req_operand_a,
   input  logic signed [fpa_pkg::WordBits-1:0]  req_operand_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fpa_pkg::WordBits-1:0]  rsp_result_value,
   output logic                                 rsp_compare_true,
   output logic [1:0]                           rsp_status
);
   import fpa_pkg::*;

   localparam int Cells = DivBits;
   localparam logic [QuotBits:0] MaxQ = (QuotBits+1)'(2**(WordBits-1) - 1);

   tag_type tag_front, tag_mul;
   tag_type tag_row [Cells+1];
   div_type div_front, div_mul;
   div_type div_row [Cells+1];
   logic [2*WordBits-1:0] prod;
   logic advance;
   logic is_mul;
   tag_type fin;
   logic [QuotBits:0] q;
   tag_type out_in, out_ff;

   // output register frees when taken; stall everything otherwise
   assign advance   = !out_ff.valid || !rsp_stall;
   assign req_stall = !advance;

   fpa_front u_front (
      .clock, .reset, .advance, .req_valid, .req_kind, .req_operand_a, .req_operand_b,
      .tag_out(tag_front), .mul_out(is_mul), .prod_out(prod), .div_out(div_front)
   );

   fpa_mul_round u_mul (
      .clock, .reset, .advance, .is_mul, .tag_in_port(tag_front), .prod,
      .div_in_port(div_front), .tag_out(tag_mul), .div_out(div_mul)
   );

   assign tag_row[0] = tag_mul;
   assign div_row[0] = div_mul;

   for (genvar i = 0; i < Cells; i++) begin : g_cell
      fpa_div_cell u_cell (
         .clock, .reset, .advance, .tag_in_port(tag_row[i]), .div_in_port(div_row[i]),
         .tag_out(tag_row[i+1]), .div_out(div_row[i+1])
      );
   end

   always_comb begin
      fin = tag_row[Cells];
      q   = {1'b0, div_row[Cells].quot};
      out_in = fin;
      if (fin.is_div && fin.status == ST_OK) begin
         if (!fin.neg) begin
            if (q > MaxQ) begin
               out_in.value = MaxQ[WordBits-1:0]; out_in.status = ST_OVF;
            end else out_in.value = q[WordBits-1:0];
         end else begin
            if (q > MaxQ + 1) begin
               out_in.value = {1'b1, {(WordBits-1){1'b0}}}; out_in.status = ST_OVF;
            end else out_in.value = WordBits'(-q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_ff.valid <= 1'b0;
      else if (advance) out_ff.valid <= out_in.valid;
      if (advance) begin
         out_ff.is_div <= out_in.is_div;
         out_ff.neg    <= out_in.neg;
         out_ff.value  <= out_in.value;
         out_ff.cmp    <= out_in.cmp;
         out_ff.status <= out_in.status;
      end
   end

   assign rsp_valid        = out_ff.valid;
   assign rsp_result_value = out_ff.value;
   assign rsp_compare_true = out_ff.cmp;
   assign rsp_status       = out_ff.status;
endmodule
